[hw/rtl/stepper_valve_position_driver_defines.svh]
// ----------------------------------------------------------------------------
// stepper valve position driver assertion macros
// checking helpers for the valve driver top level
// ----------------------------------------------------------------------------
`ifndef STEPPER_VALVE_POSITION_DRIVER_DEFINES_SVH
`define STEPPER_VALVE_POSITION_DRIVER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SVPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SVPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/svpd_pkg.sv]
// ----------------------------------------------------------------------------
// svpd_pkg
// types, constants and coil pattern lookup for the valve driver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svpd_pkg;

  localparam int POS_W     = 12;
  localparam int DLY_W     = 16;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int PROD_W    = 19;
  localparam int RCP_W     = 13;
  localparam int QUO_W     = 13;
  localparam int RCP_SHIFT = 19;

  localparam logic [PCT_W-1:0]     PCT_MAX         = 7'd100;
  localparam logic [RCP_W-1:0]     RECIP_100       = 13'd5242;
  localparam logic [PROD_W-1:0]    DIV_100         = 19'd100;
  localparam logic [POS_W-1:0]     FULL_SCALE_RST  = 12'd700;
  localparam logic [DLY_W-1:0]     PHASE_DELAY_RST = 16'd4000;

  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_DELAY = 2'd1;

  localparam logic [3:0] COIL_OFF = 4'h0;
  localparam logic [3:0] COIL_P0  = 4'hA;
  localparam logic [3:0] COIL_P1  = 4'h6;
  localparam logic [3:0] COIL_P2  = 4'h5;
  localparam logic [3:0] COIL_P3  = 4'h9;

  localparam logic [1:0] PHASE_LAST = 2'd3;

  typedef enum logic {
    KIND_CMD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  // item handed from the target pipeline to the motion stage
  typedef struct packed {
    kind_t            kind;
    logic             bad;
    logic [POS_W-1:0] tgt;
  } cmd_t;

  // closing plays the opening sequence backwards
  function automatic logic [3:0] coil_pattern(input logic dir, input logic [1:0] ph);
    logic [1:0] idx;
    idx = dir ? ph : ~ph;
    case (idx)
      2'd0:    coil_pattern = COIL_P0;
      2'd1:    coil_pattern = COIL_P1;
      2'd2:    coil_pattern = COIL_P2;
      default: coil_pattern = COIL_P3;
    endcase
  endfunction

endpackage

`default_nettype wire

[hw/rtl/svpd_target.sv]
// ----------------------------------------------------------------------------
// svpd_target
// four stage pipeline turning a percent command into a step target
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svpd_target (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      kind,
  input  wire logic [svpd_pkg::PCT_W-1:0] percent,
  input  wire logic [svpd_pkg::POS_W-1:0] full_scale,
  output logic                           item_valid,
  input  wire logic                      item_ready,
  output svpd_pkg::cmd_t                 item
);
  import svpd_pkg::*;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  kind_t              s1_kind;
  logic [PCT_W-1:0]   s1_pct;
  kind_t              s2_kind;
  logic               s2_bad;
  logic [PROD_W-1:0]  s2_prod;
  kind_t              s3_kind;
  logic               s3_bad;
  logic [PROD_W-1:0]  s3_prod;
  logic [QUO_W-1:0]   s3_quo;
  cmd_t               s4;

  logic [PROD_W+RCP_W-1:0] rcp_prod;
  logic [PROD_W-1:0]       quo_x100;
  logic [PROD_W-1:0]       rem;
  logic [QUO_W-1:0]        quo_fix;

  // a stage moves when it is empty or the one below is moving
  assign en4        = !v4 || item_ready;
  assign en3        = !v3 || en4;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign in_ready   = en1;
  assign item_valid = v4;
  assign item       = s4;

  // floor(prod / 100) by reciprocal, low by at most one
  assign rcp_prod = {{RCP_W{1'b0}}, s2_prod} * {{PROD_W{1'b0}}, RECIP_100};

  assign quo_x100 = ({{(PROD_W-QUO_W){1'b0}}, s3_quo} << 6)
                  + ({{(PROD_W-QUO_W){1'b0}}, s3_quo} << 5)
                  + ({{(PROD_W-QUO_W){1'b0}}, s3_quo} << 2);
  assign rem      = s3_prod - quo_x100;
  assign quo_fix  = (rem >= DIV_100) ? s3_quo + 1'b1 : s3_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_kind <= kind_t'(kind);
      s1_pct  <= percent;
    end
    if (en2) begin
      s2_kind <= s1_kind;
      s2_bad  <= s1_pct > PCT_MAX;
      s2_prod <= {{(PROD_W-PCT_W){1'b0}}, s1_pct} * {{(PROD_W-POS_W){1'b0}}, full_scale};
    end
    if (en3) begin
      s3_kind <= s2_kind;
      s3_bad  <= s2_bad;
      s3_prod <= s2_prod;
      s3_quo  <= rcp_prod[RCP_SHIFT +: QUO_W];
    end
    if (en4) begin
      s4.kind <= s3_kind;
      s4.bad  <= s3_bad;
      s4.tgt  <= quo_fix[POS_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/svpd_motion.sv]
// ----------------------------------------------------------------------------
// svpd_motion
// move state, coil phase sequencing and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svpd_motion (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      item_valid,
  output logic                           item_ready,
  input  wire svpd_pkg::cmd_t            item,
  input  wire logic [svpd_pkg::DLY_W-1:0] phase_delay,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [3:0]                     coils,
  output logic [svpd_pkg::POS_W-1:0]     position,
  output logic                           busy_res,
  output logic                           opening,
  output logic                           rejected
);
  import svpd_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] target, target_next;
  logic [POS_W-1:0] steps_left, steps_left_next;
  logic             dir, dir_next;
  logic [1:0]       phase, phase_next;
  logic [DLY_W-1:0] tick, tick_next;
  logic             moving, moving_next;
  logic [3:0]       coil, coil_next;
  logic             rej;
  logic             take;
  logic [DLY_W:0]   tick_inc;

  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;
  assign tick_inc   = {1'b0, tick} + 1'b1;

  always_comb begin
    pos_next        = pos;
    target_next     = target;
    steps_left_next = steps_left;
    dir_next        = dir;
    phase_next      = phase;
    tick_next       = tick;
    moving_next     = moving;
    coil_next       = coil;
    rej             = 1'b0;
    if (item.kind == KIND_CMD) begin
      if (moving || item.bad) begin
        rej = 1'b1;
      end else begin
        target_next = item.tgt;
        if (item.tgt != pos) begin
          dir_next        = item.tgt > pos;
          steps_left_next = (item.tgt > pos) ? item.tgt - pos : pos - item.tgt;
          phase_next      = 2'd0;
          tick_next       = '0;
          moving_next     = 1'b1;
          coil_next       = coil_pattern(item.tgt > pos, 2'd0);
        end
      end
    end else if (moving) begin
      if (tick_inc >= {1'b0, phase_delay}) begin
        tick_next = '0;
        if (phase == PHASE_LAST) begin
          phase_next      = 2'd0;
          steps_left_next = steps_left - 1'b1;
        end else begin
          phase_next = phase + 1'b1;
        end
        // end of the last step: coils off, position catches up
        if (phase_next == 2'd0 && steps_left_next == '0) begin
          moving_next = 1'b0;
          coil_next   = COIL_OFF;
          pos_next    = target;
        end else begin
          coil_next = coil_pattern(dir, phase_next);
        end
      end else begin
        tick_next = tick_inc[DLY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      target     <= '0;
      steps_left <= '0;
      dir        <= 1'b0;
      phase      <= 2'd0;
      tick       <= '0;
      moving     <= 1'b0;
      coil       <= COIL_OFF;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        pos        <= pos_next;
        target     <= target_next;
        steps_left <= steps_left_next;
        dir        <= dir_next;
        phase      <= phase_next;
        tick       <= tick_next;
        moving     <= moving_next;
        coil       <= coil_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      coils    <= coil_next;
      position <= pos_next;
      busy_res <= moving_next;
      opening  <= moving_next && dir_next;
      rejected <= rej;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/stepper_valve_position_driver.sv]
// ----------------------------------------------------------------------------
// stepper_valve_position_driver
// two-coil full-step stepper driver that moves a valve to a percent command
// ----------------------------------------------------------------------------
// usage:
//   in channel  : kind 0 is a position command (percent), kind 1 one time tick
//   out channel : one word per input word with coil drive, position, busy,
//                 direction and a rejected flag for refused commands
//   cfg channel : cfg_index 0 writes the full scale step count, 1 writes
//                 phase_delay, other indexes are ignored; always ready, write
//                 only while idle
// path: a word is registered at the input, then passes the target product,
//   reciprocal divide by 100, correction and move update registers in turn
// throughput: one word per cycle unless out_ready stalls it; the result
//   register takes a new word in the cycle its waiting word leaves
// reset: valve at position 0, coils off, idle, registers back to 700 / 4000
// receiver stall: the result holds, words collapse bubbles inside the
//   pipeline, then in_ready drops once all four stages are full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stepper_valve_position_driver_defines.svh"

module stepper_valve_position_driver (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          kind,
  input  wire logic [svpd_pkg::PCT_W-1:0]     percent,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [3:0]                         coils,
  output logic [svpd_pkg::POS_W-1:0]         position,
  output logic                               busy_res,
  output logic                               opening,
  output logic                               rejected,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [svpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [svpd_pkg::CFG_DAT_W-1:0] cfg_data
);
  import svpd_pkg::*;

  logic [POS_W-1:0] full_scale;
  logic [DLY_W-1:0] phase_delay;
  logic             item_valid;
  logic             item_ready;
  cmd_t             item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale  <= FULL_SCALE_RST;
      phase_delay <= PHASE_DELAY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FULL_SCALE:  full_scale  <= cfg_data[POS_W-1:0];
        REG_PHASE_DELAY: phase_delay <= cfg_data[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  svpd_target u_target (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .percent    (percent),
    .full_scale (full_scale),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  svpd_motion u_motion (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .phase_delay (phase_delay),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .coils       (coils),
    .position    (position),
    .busy_res    (busy_res),
    .opening     (opening),
    .rejected    (rejected)
  );

  `SVPD_ASSERT_NOW(a_idle_not_opening, out_valid && !busy_res, !opening, "opening set while idle")
  `SVPD_ASSERT_NOW(a_idle_coils_off, out_valid && !busy_res, coils == COIL_OFF, "coils driven while idle")
  `SVPD_ASSERT_NOW(a_busy_pattern, out_valid && busy_res, coils == COIL_P0 || coils == COIL_P1 || coils == COIL_P2 || coils == COIL_P3, "illegal coil pattern")
  `SVPD_ASSERT_NEXT(a_cfg_delay, cfg_valid && cfg_index == REG_PHASE_DELAY, phase_delay == $past(cfg_data), "phase_delay write lost")

endmodule

`default_nettype wire
